>>> src/mqtt_packet_deframer_core_macros.svh
// assertion macros for the mqtt packet deframer
// used by the top level, which supplies clock and reset
`ifndef MQTT_PACKET_DEFRAMER_CORE_MACROS_SVH
`define MQTT_PACKET_DEFRAMER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define MQTTD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mqtt deframer same-cycle check failed");

// next-cycle implication, disabled during reset
`define MQTTD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mqtt deframer next-cycle check failed");

`endif

>>> src/mqttd_pkg.sv
// types, codes and helpers shared by the mqtt packet deframer
// no dependencies
`timescale 1ns / 1ps

package mqttd_pkg;

   // parser phase, one-hot
   typedef enum logic [2:0] {
      PH_TYPE = 3'b001,
      PH_LEN  = 3'b010,
      PH_PAY  = 3'b100
   } phase_type;

   // byte roles
   localparam logic [1:0] ROLE_TYPE = 2'd0;
   localparam logic [1:0] ROLE_LEN  = 2'd1;
   localparam logic [1:0] ROLE_PAY  = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_UNHANDLED = 2'd1;
   localparam logic [1:0] STATUS_PING_LEN  = 2'd2;
   localparam logic [1:0] STATUS_MALFORMED = 2'd3;

   // packet type codes that matter here
   localparam logic [3:0] TYPE_RESERVED0 = 4'd0;
   localparam logic [3:0] TYPE_UNHANDLED8 = 4'd8;
   localparam logic [3:0] TYPE_UNHANDLED10 = 4'd10;
   localparam logic [3:0] TYPE_UNHANDLED12 = 4'd12;
   localparam logic [3:0] TYPE_PINGRESP = 4'd13;
   localparam logic [3:0] TYPE_UNHANDLED14 = 4'd14;

   localparam int LEN_W = 28;

   typedef struct packed {
      phase_type          phase;
      logic [3:0]         held_type;
      logic [3:0]         held_flags;
      logic [LEN_W-1:0]   length_acc;
      logic [2:0]         length_count;
      logic [LEN_W-1:0]   payload_count;
   } state_type;

   typedef struct packed {
      logic [7:0]         byte_out;
      logic [1:0]         byte_role;
      logic [3:0]         packet_type;
      logic [3:0]         packet_flags;
      logic [LEN_W-1:0]   payload_length;
      logic [LEN_W-1:0]   payload_offset;
      logic               last_of_packet;
      logic [1:0]         status;
   } result_type;

   function automatic logic type_handled(input logic [3:0] t);
      type_handled = !(t == TYPE_RESERVED0 || t == TYPE_UNHANDLED8 ||
                       t == TYPE_UNHANDLED10 || t == TYPE_UNHANDLED12 ||
                       t == TYPE_UNHANDLED14);
   endfunction

   // status for a byte that is not a malformed length byte
   function automatic logic [1:0] normal_status(input logic [3:0] t,
                                                input logic length_known,
                                                input logic [LEN_W-1:0] acc);
      if (t == TYPE_PINGRESP && length_known && acc != '0) begin
         normal_status = STATUS_PING_LEN;
      end else if (!type_handled(t)) begin
         normal_status = STATUS_UNHANDLED;
      end else begin
         normal_status = STATUS_OK;
      end
   endfunction

endpackage

>>> src/mqttd_decode.sv
// per-byte decode: next parser state and the result for one byte
// depends on mqttd_pkg
`timescale 1ns / 1ps

module mqttd_decode
   import mqttd_pkg::*;
#(
   parameter int MAX_LENGTH_BYTES = 4
) (
   input  logic [7:0]  data_byte,
   input  state_type   cur,
   output state_type   nxt,
   output result_type  res
);

   localparam logic [2:0] LEN_LIMIT = 3'(MAX_LENGTH_BYTES);

   logic [LEN_W-1:0] acc_add;
   logic [LEN_W-1:0] acc_new;
   logic [2:0]       count_new;
   logic [LEN_W-1:0] pay_new;

   // place the seven length bits at their base-128 position
   always_comb begin
      case (cur.length_count[1:0])
         2'd0: acc_add = {21'd0, data_byte[6:0]};
         2'd1: acc_add = {14'd0, data_byte[6:0], 7'd0};
         2'd2: acc_add = {7'd0, data_byte[6:0], 14'd0};
         default: acc_add = {data_byte[6:0], 21'd0};
      endcase
   end

   assign acc_new   = cur.length_acc | acc_add;
   assign count_new = cur.length_count + 3'd1;
   assign pay_new   = cur.payload_count + LEN_W'(1);

   // phase handling
   always_comb begin
      nxt = cur;
      res.byte_out       = data_byte;
      res.byte_role      = ROLE_TYPE;
      res.packet_type    = cur.held_type;
      res.packet_flags   = cur.held_flags;
      res.payload_length = '0;
      res.payload_offset = '0;
      res.last_of_packet = 1'b0;
      res.status         = STATUS_OK;
      case (cur.phase)
         PH_LEN: begin
            res.byte_role      = ROLE_LEN;
            nxt.length_acc     = acc_new;
            nxt.length_count   = count_new;
            res.payload_length = acc_new;
            if (data_byte[7]) begin
               if (count_new >= LEN_LIMIT) begin
                  res.status         = STATUS_MALFORMED;
                  res.last_of_packet = 1'b1;
                  nxt.phase          = PH_TYPE;
               end else begin
                  res.status = normal_status(cur.held_type, 1'b0, acc_new);
               end
            end else begin
               res.status = normal_status(cur.held_type, 1'b1, acc_new);
               if (acc_new == '0) begin
                  res.last_of_packet = 1'b1;
                  nxt.phase          = PH_TYPE;
               end else begin
                  nxt.payload_count = '0;
                  nxt.phase         = PH_PAY;
               end
            end
         end
         PH_PAY: begin
            res.byte_role      = ROLE_PAY;
            res.payload_offset = cur.payload_count;
            res.payload_length = cur.length_acc;
            res.status         = normal_status(cur.held_type, 1'b1, cur.length_acc);
            nxt.payload_count  = pay_new;
            if (pay_new >= cur.length_acc) begin
               res.last_of_packet = 1'b1;
               nxt.phase          = PH_TYPE;
            end
         end
         default: begin
            // type/flags byte, also taken in any unused phase code
            nxt.held_type     = data_byte[7:4];
            nxt.held_flags    = data_byte[3:0];
            nxt.length_acc    = '0;
            nxt.length_count  = '0;
            nxt.payload_count = '0;
            nxt.phase         = PH_LEN;
            res.packet_type   = data_byte[7:4];
            res.packet_flags  = data_byte[3:0];
            res.status        = normal_status(data_byte[7:4], 1'b0, '0);
         end
      endcase
   end

endmodule

>>> src/mqtt_packet_deframer_core.sv
// mqtt fixed header deframer: one byte in, one annotated byte out
// a byte accepted on the request channel is registered, decoded, and its result
// registered onto the result channel once the output stage is free
// throughput: one byte per cycle through the single-pass decode stage, unless rsp_tready stalls it
// reset: synchronous, clears both stage valids and returns the parser to
// expecting a type byte with all counters at zero
`timescale 1ns / 1ps
`include "mqtt_packet_deframer_core_macros.svh"

module mqtt_packet_deframer_core
   import mqttd_pkg::*;
#(
   parameter int MAX_LENGTH_BYTES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // byte_out, packet_type, packet_flags,
                                    // payload_length, payload_offset
   output logic [3:0]  rsp_tuser,   // byte_role, status
   output logic        rsp_tlast    // last_of_packet
);

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_data_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type res;
   logic       out_free;
   logic       advance;

   // stage handshakes
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign advance      = in_valid_ff && out_free;
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   mqttd_decode #(
      .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
   ) u_decode (
      .data_byte(in_data_ff),
      .cur      (state_ff),
      .nxt      (state_in),
      .res      (res)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         state_ff.phase         <= PH_TYPE;
         state_ff.held_type     <= '0;
         state_ff.held_flags    <= '0;
         state_ff.length_acc    <= '0;
         state_ff.length_count  <= '0;
         state_ff.payload_count <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
      end
      if (advance) begin
         rsp_ff <= res;
      end
   end

   // result transaction
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.payload_offset, rsp_ff.payload_length,
                        rsp_ff.packet_flags, rsp_ff.packet_type, rsp_ff.byte_out};
   assign rsp_tuser  = {rsp_ff.status, rsp_ff.byte_role};
   assign rsp_tlast  = rsp_ff.last_of_packet;

   // a malformed length always ends the packet on a length byte
   `MQTTD_ASSERT_SAME(a_malformed_ends, rsp_valid_ff && rsp_ff.status == STATUS_MALFORMED, rsp_ff.last_of_packet && rsp_ff.byte_role == ROLE_LEN)
   // a type byte never ends a packet
   `MQTTD_ASSERT_SAME(a_type_not_last, rsp_valid_ff && rsp_ff.byte_role == ROLE_TYPE, !rsp_ff.last_of_packet)
   // payload offsets stay inside the decoded length
   `MQTTD_ASSERT_SAME(a_offset_in_range, rsp_valid_ff && rsp_ff.byte_role == ROLE_PAY, rsp_ff.payload_offset < rsp_ff.payload_length)
   // the byte after a packet end is parsed as a type byte
   `MQTTD_ASSERT_NEXT(a_end_to_type, advance && res.last_of_packet, state_ff.phase == PH_TYPE)

endmodule
